FILE: hdl/i128au_pkg.sv
// Package for the 128-bit integer arithmetic unit.
// Holds the opcodes, the input item type and the pipeline stage payload.
// No dependencies.
package i128au_pkg;

  // Dividend width; the divider retires one quotient bit per stage
  localparam int unsigned DIV_BITS = 128;
  localparam int unsigned HALF_W   = 64;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_SUB    = 3'd1,
    OP_NEG    = 3'd2,
    OP_SEXT   = 3'd3,
    OP_SQUARE = 3'd4,
    OP_UDIV   = 3'd5,
    OP_SDIV   = 3'd6,
    OP_SHIFT  = 3'd7
  } opcode_t;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [63:0]       a_low;
    logic [63:0]       a_high;
    logic [63:0]       b_low;
    logic [63:0]       b_high;
    logic signed [6:0] shift_amount;
  } in_item_t;

  // Payload carried through the divide stages. For divides, work holds the
  // remaining dividend bits on the left and quotient bits shifted in on the
  // right; for every other opcode it holds the finished result.
  typedef struct packed {
    logic         is_div;    // run a restoring step in each divide stage
    logic         neg_quo;   // negate the quotient at the end (signed divide)
    logic         keep_rem;  // report the remainder (unsigned divide)
    logic         dz;        // divide by zero
    logic [127:0] work;
    logic [63:0]  rem;
    logic [63:0]  divisor;
  } stage_t;

endpackage

FILE: hdl/i128au_in_if.sv
// Input channel of the 128-bit arithmetic unit: valid/ready plus operands.
// Depends on nothing.
interface i128au_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        opcode;
  logic [63:0]       a_low;
  logic [63:0]       a_high;
  logic [63:0]       b_low;
  logic [63:0]       b_high;
  logic signed [6:0] shift_amount;

  modport source (output valid, opcode, a_low, a_high, b_low, b_high, shift_amount,
                  input ready);
  modport sink (input valid, opcode, a_low, a_high, b_low, b_high, shift_amount,
                output ready);
endinterface

FILE: hdl/i128au_out_if.sv
// Result channel of the 128-bit arithmetic unit: valid/ready plus result.
// Depends on nothing.
interface i128au_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_low;
  logic [63:0] result_high;
  logic [63:0] remainder_out;
  logic        result_negative;
  logic        divide_by_zero;

  modport source (output valid, result_low, result_high, remainder_out,
                  result_negative, divide_by_zero, input ready);
  modport sink (input valid, result_low, result_high, remainder_out,
                result_negative, divide_by_zero, output ready);
endinterface

FILE: hdl/i128au_div_step.sv
// One registered stage of the pipelined 128-by-64 restoring divider.
// Depends on i128au_pkg (stage_t).
module i128au_div_step
  import i128au_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  stage_t in_data,
  output logic   out_valid,
  output stage_t out_data
);

  logic [64:0] diff;
  logic        take;
  stage_t      step;

  // Shift in the next dividend bit and try to subtract the divisor
  always_comb begin
    diff = {in_data.rem, in_data.work[127]} - {1'b0, in_data.divisor};
    take = ~diff[64];
    step = in_data;
    if (in_data.is_div) begin
      step.work = {in_data.work[126:0], take};
      step.rem  = take ? diff[63:0] : {in_data.rem[62:0], in_data.work[127]};
    end
  end

  // Advance on enable; hold on stall
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= step;
    end
  end

endmodule

FILE: hdl/int128_arithmetic_unit.sv
// 128-bit integer arithmetic unit: add, sub, negate, sign-extend, square,
// 128/64 unsigned and signed divide, signed shift.
// Accepts one item per cycle while the skid stage is empty; the divider is a
// 128-stage pipeline that retires one quotient bit per stage. Reset (rst,
// synchronous) clears all valid bits; payload is not reset.
module int128_arithmetic_unit
  import i128au_pkg::*;
(
  input logic      clk,
  input logic      rst,
  i128au_in_if.sink    req,
  i128au_out_if.source rsp
);

  logic     en;
  logic     s0_valid, s1_valid, s1_sq, s2_valid, s2_sq, s3_valid;
  in_item_t s0;
  stage_t   s1, s2, s3, p1;
  logic     p1_sq;
  logic [63:0] s2_lh, s2_hh;
  logic [127:0] a_w, b_w;
  logic [6:0]   rsh;
  logic [31:0]  m_lo, m_hi;
  stage_t   st2_next, st3_next;

  logic   dv [DIV_BITS+1];
  stage_t dp [DIV_BITS+1];

  logic         out_valid, skid_valid, incoming, pop;
  logic [127:0] fin_res;
  logic [63:0]  fin_rem;
  logic [127:0] out_res, skid_res;
  logic [63:0]  out_rem, skid_rem;
  logic         out_dz, skid_dz;

  // Pipeline moves whenever the skid stage is empty
  assign en        = ~skid_valid;
  assign req.ready = en;

  // Capture the input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0 <= '{opcode: req.opcode, a_low: req.a_low, a_high: req.a_high,
              b_low: req.b_low, b_high: req.b_high, shift_amount: req.shift_amount};
    end
  end

  // Stage 1: simple ops finish here; square and divide operands are prepared
  always_comb begin
    a_w   = {s0.a_high, s0.a_low};
    b_w   = {s0.b_high, s0.b_low};
    rsh   = 7'(-s0.shift_amount);
    p1    = '0;
    p1_sq = 1'b0;
    unique case (opcode_t'(s0.opcode))
      OP_ADD:  p1.work = a_w + b_w;
      OP_SUB:  p1.work = a_w - b_w;
      OP_NEG:  p1.work = 128'(0) - a_w;
      OP_SEXT: p1.work = {{64{s0.a_low[63]}}, s0.a_low};
      OP_SQUARE: begin
        p1_sq   = 1'b1;
        p1.work = {64'b0, s0.a_low[63] ? 64'(64'(0) - s0.a_low) : s0.a_low};
      end
      OP_UDIV, OP_SDIV: begin
        if (s0.b_low == 64'b0) begin
          p1.dz = 1'b1;
        end else begin
          p1.is_div   = 1'b1;
          p1.divisor  = s0.b_low;
          p1.keep_rem = (opcode_t'(s0.opcode) == OP_UDIV);
          p1.neg_quo  = (opcode_t'(s0.opcode) == OP_SDIV) && a_w[127];
          p1.work     = p1.neg_quo ? 128'(0) - a_w : a_w;
        end
      end
      OP_SHIFT: begin
        if (s0.shift_amount[6]) begin
          p1.work = 128'($signed(a_w) >>> rsh);
        end else begin
          p1.work = a_w << s0.shift_amount[5:0];
        end
      end
      default: p1.work = '0;
    endcase
  end

  // Stage 2: partial products of the square magnitude
  always_comb begin
    m_lo     = s1.work[31:0];
    m_hi     = s1.work[63:32];
    st2_next = s1;
    if (s1_sq) begin
      st2_next.work = {64'b0, 64'(m_lo) * 64'(m_lo)};
    end
  end

  // Stage 3: sum the partial products
  always_comb begin
    st3_next = s2;
    if (s2_sq) begin
      st3_next.work = {s2_hh, 64'b0} + (128'(s2_lh) << 33) + s2.work;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1    <= p1;
      s1_sq <= p1_sq;
      s2    <= st2_next;
      s2_sq <= s1_sq;
      s2_lh <= 64'(m_lo) * 64'(m_hi);
      s2_hh <= 64'(m_hi) * 64'(m_hi);
      s3    <= st3_next;
    end
  end

  // Divider: one quotient bit per stage
  assign dv[0] = s3_valid;
  assign dp[0] = s3;

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_div
    i128au_div_step u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (dv[i]),
      .in_data  (dp[i]),
      .out_valid(dv[i+1]),
      .out_data (dp[i+1])
    );
  end

  // Final sign fix-up and remainder select
  always_comb begin
    fin_res = dp[DIV_BITS].neg_quo ? 128'(0) - dp[DIV_BITS].work : dp[DIV_BITS].work;
    fin_rem = dp[DIV_BITS].keep_rem ? dp[DIV_BITS].rem : 64'b0;
  end

  assign incoming = en && dv[DIV_BITS];
  assign pop      = out_valid && rsp.ready;

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= incoming;
      end
    end else if (!out_valid) begin
      out_valid <= incoming;
    end else if (incoming) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      out_res <= skid_res;
      out_rem <= skid_rem;
      out_dz  <= skid_dz;
    end else if (pop || !out_valid) begin
      out_res <= fin_res;
      out_rem <= fin_rem;
      out_dz  <= dp[DIV_BITS].dz;
    end
    if (!pop && out_valid && incoming) begin
      skid_res <= fin_res;
      skid_rem <= fin_rem;
      skid_dz  <= dp[DIV_BITS].dz;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.result_low      = out_res[63:0];
  assign rsp.result_high     = out_res[127:64];
  assign rsp.remainder_out   = out_rem;
  assign rsp.result_negative = out_res[127];
  assign rsp.divide_by_zero  = out_dz;

`ifndef ASSERT_OFF
  a_dz_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_dz) |-> (out_res == 128'b0 && out_rem == 64'b0))
    else $error("divide by zero result not cleared");

  a_skid_has_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage full while output register empty");

  a_skid_fill : assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !rsp.ready))
    else $error("skid stage filled without a stalled output");
`endif

endmodule

FILE: dv/i128au_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the 128-bit arithmetic unit: watches both channels,
// computes the expected result of each input transfer and compares.
// Depends on i128au_pkg, i128au_in_if and i128au_out_if.
module i128au_checker
  import i128au_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  i128au_in_if        req,
  i128au_out_if       rsp,
  output int unsigned fail_count,
  output int unsigned pending_count,
  output int unsigned result_count
);

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] rem;
    logic        neg;
    logic        dz;
  } alu_result_t;

  alu_result_t expected_results[$];

  // Compute the result of one operation at full width
  function automatic alu_result_t compute_result(in_item_t it);
    alu_result_t  r;
    logic [127:0] a, b, v, mag, q;
    logic [63:0]  m;
    logic [6:0]   amt;
    int           s;
    a = {it.a_high, it.a_low};
    b = {it.b_high, it.b_low};
    v = '0;
    r = '0;
    case (opcode_t'(it.opcode))
      OP_ADD: v = a + b;
      OP_SUB: v = a - b;
      OP_NEG: v = -a;
      OP_SEXT: v = {{64{it.a_low[63]}}, it.a_low};
      OP_SQUARE: begin
        m = it.a_low[63] ? -it.a_low : it.a_low;
        v = {64'd0, m} * {64'd0, m};
      end
      OP_UDIV: begin
        if (it.b_low == 0) r.dz = 1'b1;
        else begin
          v = a / {64'd0, it.b_low};
          r.rem = 64'(a % {64'd0, it.b_low});
        end
      end
      OP_SDIV: begin
        if (it.b_low == 0) r.dz = 1'b1;
        else begin
          mag = a[127] ? -a : a;
          q = mag / {64'd0, it.b_low};
          v = a[127] ? -q : q;
        end
      end
      default: begin
        amt = it.shift_amount;
        if (amt[6]) begin
          s = 128 - amt;
          v = $signed(a) >>> s;
        end else begin
          v = a << amt[5:0];
        end
      end
    endcase
    r.lo = v[63:0];
    r.hi = v[127:64];
    r.neg = v[127];
    return r;
  endfunction

  // Predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    in_item_t    it;
    alu_result_t got, want;
    if (rst) begin
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (req.valid && req.ready) begin
        it = {req.opcode, req.a_low, req.a_high, req.b_low, req.b_high, req.shift_amount};
        expected_results.push_back(compute_result(it));
      end
      if (rsp.valid && rsp.ready) begin
        got = {rsp.result_low, rsp.result_high, rsp.remainder_out,
               rsp.result_negative, rsp.divide_by_zero};
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected lo=%h hi=%h rem=%h neg=%b dz=%b", $time,
                     want.lo, want.hi, want.rem, want.neg, want.dz);
            $display("%0t:          actual   lo=%h hi=%h rem=%h neg=%b dz=%b", $time,
                     got.lo, got.hi, got.rem, got.neg, got.dz);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_count = expected_results.size();
  end

endmodule

FILE: dv/tb_int128_arithmetic_unit.sv
`timescale 1ns / 1ps
// Testbench top for the 128-bit arithmetic unit: directed and random
// operations with random gaps and stalls. Depends on i128au_checker and the RTL.
module tb_int128_arithmetic_unit;
  import i128au_pkg::*;

  localparam int LATENCY = 132;
  localparam int RANDOM_ITEMS = 2000;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int unsigned fail_count, pending_count, result_count;
  longint cycles = 0;
  bit long_stall = 1'b0;
  bit in_done = 1'b0;

  i128au_in_if  req ();
  i128au_out_if rsp ();

  int128_arithmetic_unit uut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));
  i128au_checker chk (.clk(clk), .rst(rst), .req(req), .rsp(rsp),
                      .fail_count(fail_count), .pending_count(pending_count),
                      .result_count(result_count));

  always #2 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_int128_arithmetic_unit: done, errors");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = 64'd0;
      1: v = '1;
      2: v = 64'h8000000000000000;
      3: v = 64'h7fffffffffffffff;
      4: v = 64'($urandom_range(0, 9));
      5: v = -64'($urandom_range(1, 9));
      default: ;
    endcase
    return v;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                        : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
  endfunction

  // Offer one item and hold it until the transfer
  task automatic send_op(opcode_t op, logic [63:0] al, logic [63:0] ah,
                         logic [63:0] bl, logic [63:0] bh, logic signed [6:0] sh);
    req.valid <= 1'b1;
    req.opcode <= op;
    req.a_low <= al;
    req.a_high <= ah;
    req.b_low <= bl;
    req.b_high <= bh;
    req.shift_amount <= sh;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic idle_input(int n);
    if (n > 0) begin
      req.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int n;
    rsp.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_stall) begin
        rsp.ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_stall = 1'b0;
      end
      n = in_done ? 0 : gap_len();
      if (n > 0) begin
        rsp.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      rsp.ready <= 1'b1;
    end
  end

  initial begin
    logic [63:0] al, ah;
    int tail;
    req.valid = 1'b0;
    req.opcode = OP_ADD;
    req.a_low = '0;
    req.a_high = '0;
    req.b_low = '0;
    req.b_high = '0;
    req.shift_amount = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners
    send_op(OP_ADD, '1, '1, 64'd1, 64'd0, 0);
    send_op(OP_SUB, 64'd0, 64'd0, 64'd1, 64'd0, 0);
    send_op(OP_NEG, 64'd0, 64'h8000000000000000, 0, 0, 0);
    send_op(OP_NEG, 64'd0, 64'd0, 0, 0, 0);
    send_op(OP_SEXT, 64'h8000000000000000, '1, 0, 0, 0);
    send_op(OP_SEXT, 64'h7fffffffffffffff, 0, 0, 0, 0);
    send_op(OP_SQUARE, 64'h8000000000000000, 0, 0, 0, 0);
    send_op(OP_SQUARE, '1, '1, 0, 0, 0);
    send_op(OP_UDIV, '1, '1, 64'd0, '1, 0);
    send_op(OP_UDIV, '1, '1, 64'd1, 0, 0);
    send_op(OP_UDIV, '1, '1, '1, 0, 0);
    send_op(OP_SDIV, '1, '1, 64'd0, 0, 0);
    send_op(OP_SDIV, 64'd0, 64'h8000000000000000, 64'd1, 0, 0);
    send_op(OP_SDIV, 64'd0, 64'h8000000000000000, 64'd3, 0, 0);
    send_op(OP_SDIV, 64'd7, '1, 64'd2, 0, 0);
    send_op(OP_SHIFT, 64'h0123456789abcdef, 64'h8000000000000001, 0, 0, 7'sd0);
    send_op(OP_SHIFT, 64'h0123456789abcdef, 64'h8000000000000001, 0, 0, 7'sd63);
    send_op(OP_SHIFT, 64'h0123456789abcdef, 64'h8000000000000001, 0, 0, -7'sd63);
    send_op(OP_SHIFT, 64'h0123456789abcdef, 64'h8000000000000001, 0, 0, -7'sd64);
    send_op(OP_SHIFT, '1, 64'h7fffffffffffffff, 0, 0, -7'sd1);
    send_op(OP_SHIFT, '1, '1, 0, 0, 7'sd1);

    // Pause until everything is back
    idle_input(1);
    while (pending_count != 0) @(posedge clk);

    // Random operations; hold off the receiver once mid-run
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 300) long_stall = 1'b1;
      if (i == 1200) begin
        idle_input(1);
        while (pending_count != 0) @(posedge clk);
      end
      al = rand64();
      ah = rand64();
      send_op(opcode_t'($urandom_range(0, 7)), al, ah, rand64(), rand64(),
              7'($urandom_range(0, 127)));
      if (i < 200 || i > 1800) idle_input(gap_len());
    end
    req.valid <= 1'b0;
    in_done = 1'b1;

    // Drain
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Covered all eight opcodes: %0d directed and %0d random items, %0d results.",
             21, RANDOM_ITEMS, result_count);
    if (fail_count == 0 && pending_count == 0)
      $display("tb_int128_arithmetic_unit: done, clean");
    else
      $display("tb_int128_arithmetic_unit: done, errors");
    $finish;
  end

endmodule
